// ----- design/spq_pkg.sv -----
// Shared types and constants for the stable priority queue.
// No dependencies; every other design file refers to this package by scoped names.
package spq_pkg;

	// Number of entries the queue can hold.
	localparam int unsigned Capacity = 64;
	// Width of the held count (must hold Capacity itself) and of an entry index.
	localparam int unsigned CountW   = $clog2(Capacity + 1);
	localparam int unsigned IdxW     = $clog2(Capacity);

	// Field widths of one transfer.
	localparam int unsigned TagW     = 16;
	localparam int unsigned KindW    = 8;
	localparam int unsigned PrioW    = 32;
	localparam int unsigned CountOutW = 7;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;  // take the request and register the per-entry compares
		logic exec;     // apply the operation and register the result
	} cmd_t;

endpackage

// ----- design/spq_ctrl.sv -----
// Controller for the stable priority queue: a two-state sequencer.
// Depends on spq_pkg for the state and command types.
module spq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	output spq_pkg::cmd_t  cmd
);

	spq_pkg::state_t state_q;
	spq_pkg::state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				if (start) begin
					state_nx = spq_pkg::S_EXEC;
				end
			end
			spq_pkg::S_EXEC: begin
				state_nx = spq_pkg::S_IDLE;
			end
			default: begin
				state_nx = spq_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy        = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		unique case (state_q)
			spq_pkg::S_IDLE: begin
				cmd.capture = start;
			end
			spq_pkg::S_EXEC: begin
				busy     = 1'b1;
				cmd.exec = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/spq_datapath.sv -----
// Datapath for the stable priority queue: sorted entry cells, per-entry
// compare registers, held count and result registers. Depends on spq_pkg.
module spq_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  spq_pkg::cmd_t                     cmd,
	input  logic                              func,
	input  logic [spq_pkg::TagW-1:0]          item_tag,
	input  logic [spq_pkg::KindW-1:0]         kind,
	input  logic signed [spq_pkg::PrioW-1:0]  priority_req,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [spq_pkg::TagW-1:0]          out_tag,
	output logic [spq_pkg::KindW-1:0]         out_kind,
	output logic signed [spq_pkg::PrioW-1:0]  out_priority,
	output logic [spq_pkg::CountOutW-1:0]     count
);

	localparam int unsigned Cap = spq_pkg::Capacity;

	// Entry cells, head at position 0.
	logic [spq_pkg::TagW-1:0]         tag_q  [Cap];
	logic [spq_pkg::KindW-1:0]        kind_q [Cap];
	logic signed [spq_pkg::PrioW-1:0] prio_q [Cap];
	logic [spq_pkg::CountW-1:0]       cnt_q;

	// Request and compare vectors registered at the accepting edge.
	spq_pkg::func_t                   func_s1;
	logic [spq_pkg::TagW-1:0]         tag_s1;
	logic [spq_pkg::KindW-1:0]        kind_s1;
	logic signed [spq_pkg::PrioW-1:0] prio_s1;
	logic [Cap-1:0]                   match_s1;
	logic [Cap-1:0]                   le_s1;

	logic       dup;
	logic       full;
	logic       empty;
	logic       do_ins;
	logic       do_rem;

	assign dup    = |match_s1;
	assign full   = (cnt_q == spq_pkg::CountW'(Cap));
	assign empty  = (cnt_q == '0);
	assign do_ins = cmd.exec && (func_s1 == spq_pkg::FUNC_INSERT) && !dup && !full;
	assign do_rem = cmd.exec && (func_s1 == spq_pkg::FUNC_REMOVE) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_s1 <= spq_pkg::func_t'(func);
			tag_s1  <= item_tag;
			kind_s1 <= kind;
			prio_s1 <= priority_req;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < Cap; gi++) begin : g_cell
			localparam logic [spq_pkg::CountW-1:0] Pos = spq_pkg::CountW'(gi);
			logic held;

			assign held = (Pos < cnt_q);

			// Only held entries take part, so never-written cells are ignored.
			always_ff @(posedge clk) begin
				if (cmd.capture) begin
					match_s1[gi] <= held && (tag_q[gi] == item_tag);
					le_s1[gi]    <= held && (prio_q[gi] <= priority_req);
				end
			end

			// The le vector is a prefix of ones: cells ahead of the insert point
			// keep their entry, the first cell behind it takes the new entry and
			// the rest take their neighbor toward the head.
			always_ff @(posedge clk) begin
				if (do_ins && !le_s1[gi]) begin
					if (gi == 0) begin
						tag_q[gi]  <= tag_s1;
						kind_q[gi] <= kind_s1;
						prio_q[gi] <= prio_s1;
					end else if (le_s1[(gi == 0) ? 0 : gi - 1]) begin
						tag_q[gi]  <= tag_s1;
						kind_q[gi] <= kind_s1;
						prio_q[gi] <= prio_s1;
					end else begin
						tag_q[gi]  <= tag_q[(gi == 0) ? 0 : gi - 1];
						kind_q[gi] <= kind_q[(gi == 0) ? 0 : gi - 1];
						prio_q[gi] <= prio_q[(gi == 0) ? 0 : gi - 1];
					end
				end else if (do_rem && (gi < Cap - 1)) begin
					tag_q[gi]  <= tag_q[(gi < Cap - 1) ? gi + 1 : gi];
					kind_q[gi] <= kind_q[(gi < Cap - 1) ? gi + 1 : gi];
					prio_q[gi] <= prio_q[(gi < Cap - 1) ? gi + 1 : gi];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= cmd.exec;
			if (do_ins) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rem) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Only a successful removal carries the head entry; every other result has a zero payload.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			priority if (func_s1 == spq_pkg::FUNC_INSERT) begin
				out_tag      <= '0;
				out_kind     <= '0;
				out_priority <= '0;
				if (dup) begin
					status <= spq_pkg::ST_DUP;
				end else if (full) begin
					status <= spq_pkg::ST_FULL;
				end else begin
					status <= spq_pkg::ST_OK;
				end
			end else if (empty) begin
				status       <= spq_pkg::ST_EMPTY;
				out_tag      <= '0;
				out_kind     <= '0;
				out_priority <= '0;
			end else begin
				status       <= spq_pkg::ST_OK;
				out_tag      <= tag_q[0];
				out_kind     <= kind_q[0];
				out_priority <= prio_q[0];
			end
		end
	end

	assign count = spq_pkg::CountOutW'(cnt_q);

endmodule

// ----- design/stable_priority_queue.sv -----
// Stable minimum-priority queue: top level joining controller and datapath.
// The accepting edge registers the request and the per-entry compares; the result strobe and
// the result are registered at the edge that ends the busy cycle.
// No request is taken while busy; busy is high for the one cycle that ends with
// the sorted cells shifting, and the next request is taken once the sequencer is idle again.
// Reset (arst_n low) empties the queue and idles the sequencer; the receiver cannot stall.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
module stable_priority_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic [spq_pkg::TagW-1:0]          item_tag,
	input  logic [spq_pkg::KindW-1:0]         kind,
	input  logic signed [spq_pkg::PrioW-1:0]  priority_req,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [spq_pkg::TagW-1:0]          out_tag,
	output logic [spq_pkg::KindW-1:0]         out_kind,
	output logic signed [spq_pkg::PrioW-1:0]  out_priority,
	output logic [spq_pkg::CountOutW-1:0]     count
);

	// The controller steps through two phases per transfer. In the accepting
	// cycle every cell compares its tag against the request and its priority
	// against the request key; those bits are registered. In the busy cycle the
	// cells shift in parallel (toward the tail behind the insert point, or toward
	// the head on a removal) and the result is registered for a one-cycle strobe.
	spq_pkg::cmd_t cmd;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Equal priorities stay in arrival order because a new entry lands behind
	// every held entry whose priority is smaller or equal.
	spq_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.func         (func),
		.item_tag     (item_tag),
		.kind         (kind),
		.priority_req (priority_req),
		.done         (done),
		.status       (status),
		.out_tag      (out_tag),
		.out_kind     (out_kind),
		.out_priority (out_priority),
		.count        (count)
	);

endmodule

// ----- design/spq_checker.sv -----
// Port-level checker for the stable priority queue, bound to the top level.
// Depends on spq_pkg for the status codes.
module spq_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic                              done,
	input logic [1:0]                        status,
	input logic [spq_pkg::TagW-1:0]          out_tag,
	input logic [spq_pkg::KindW-1:0]         out_kind,
	input logic signed [spq_pkg::PrioW-1:0]  out_priority,
	input logic [spq_pkg::CountOutW-1:0]     count
);

	// An accepted request makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// Every busy cycle is followed by exactly one result transfer.
	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("busy cycle not followed by a result");

	// A result only follows a busy cycle.
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a preceding busy cycle");

	// A refused operation carries a zero payload.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != spq_pkg::ST_OK) |->
			(out_tag == '0) && (out_kind == '0) && (out_priority == '0))
		else $error("payload not zero on a refused operation");

	// An empty status reports an empty queue.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == spq_pkg::ST_EMPTY) |-> (count == '0))
		else $error("empty status with nonzero count");

endmodule

bind stable_priority_queue spq_checker u_spq_checker (.*);
